/* src/drf_pkg.sv */
// Shared widths, DES tables and bit-mapping functions for the DES round function.
`timescale 1ns / 1ps

package drf_pkg;

    localparam int RH_W  = 32;
    localparam int KEY_W = 48;
    localparam int EXP_W = 48;
    localparam int F_W   = 32;

    // Expansion table, DES bit numbers, first entry lands in the MSB
    localparam int E_TAB [48] = '{
        32,  1,  2,  3,  4,  5,
         4,  5,  6,  7,  8,  9,
         8,  9, 10, 11, 12, 13,
        12, 13, 14, 15, 16, 17,
        16, 17, 18, 19, 20, 21,
        20, 21, 22, 23, 24, 25,
        24, 25, 26, 27, 28, 29,
        28, 29, 30, 31, 32,  1
    };

    // Permutation table, DES bit numbers, first entry lands in the MSB
    localparam int P_TAB [32] = '{
        16,  7, 20, 21, 29, 12, 28, 17,
         1, 15, 23, 26,  5, 18, 31, 10,
         2,  8, 24, 14, 32, 27,  3,  9,
        19, 13, 30,  6, 22, 11,  4, 25
    };

    // S-boxes S1..S8, each indexed by {row, column}
    localparam logic [3:0] SBOX_TAB [8][64] = '{
        '{14,  4, 13,  1,  2, 15, 11,  8,  3, 10,  6, 12,  5,  9,  0,  7,
           0, 15,  7,  4, 14,  2, 13,  1, 10,  6, 12, 11,  9,  5,  3,  8,
           4,  1, 14,  8, 13,  6,  2, 11, 15, 12,  9,  7,  3, 10,  5,  0,
          15, 12,  8,  2,  4,  9,  1,  7,  5, 11,  3, 14, 10,  0,  6, 13},
        '{15,  1,  8, 14,  6, 11,  3,  4,  9,  7,  2, 13, 12,  0,  5, 10,
           3, 13,  4,  7, 15,  2,  8, 14, 12,  0,  1, 10,  6,  9, 11,  5,
           0, 14,  7, 11, 10,  4, 13,  1,  5,  8, 12,  6,  9,  3,  2, 15,
          13,  8, 10,  1,  3, 15,  4,  2, 11,  6,  7, 12,  0,  5, 14,  9},
        '{10,  0,  9, 14,  6,  3, 15,  5,  1, 13, 12,  7, 11,  4,  2,  8,
          13,  7,  0,  9,  3,  4,  6, 10,  2,  8,  5, 14, 12, 11, 15,  1,
          13,  6,  4,  9,  8, 15,  3,  0, 11,  1,  2, 12,  5, 10, 14,  7,
           1, 10, 13,  0,  6,  9,  8,  7,  4, 15, 14,  3, 11,  5,  2, 12},
        '{ 7, 13, 14,  3,  0,  6,  9, 10,  1,  2,  8,  5, 11, 12,  4, 15,
          13,  8, 11,  5,  6, 15,  0,  3,  4,  7,  2, 12,  1, 10, 14,  9,
          10,  6,  9,  0, 12, 11,  7, 13, 15,  1,  3, 14,  5,  2,  8,  4,
           3, 15,  0,  6, 10,  1, 13,  8,  9,  4,  5, 11, 12,  7,  2, 14},
        '{ 2, 12,  4,  1,  7, 10, 11,  6,  8,  5,  3, 15, 13,  0, 14,  9,
          14, 11,  2, 12,  4,  7, 13,  1,  5,  0, 15, 10,  3,  9,  8,  6,
           4,  2,  1, 11, 10, 13,  7,  8, 15,  9, 12,  5,  6,  3,  0, 14,
          11,  8, 12,  7,  1, 14,  2, 13,  6, 15,  0,  9, 10,  4,  5,  3},
        '{12,  1, 10, 15,  9,  2,  6,  8,  0, 13,  3,  4, 14,  7,  5, 11,
          10, 15,  4,  2,  7, 12,  9,  5,  6,  1, 13, 14,  0, 11,  3,  8,
           9, 14, 15,  5,  2,  8, 12,  3,  7,  0,  4, 10,  1, 13, 11,  6,
           4,  3,  2, 12,  9,  5, 15, 10, 11, 14,  1,  7,  6,  0,  8, 13},
        '{ 4, 11,  2, 14, 15,  0,  8, 13,  3, 12,  9,  7,  5, 10,  6,  1,
          13,  0, 11,  7,  4,  9,  1, 10, 14,  3,  5, 12,  2, 15,  8,  6,
           1,  4, 11, 13, 12,  3,  7, 14, 10, 15,  6,  8,  0,  5,  9,  2,
           6, 11, 13,  8,  1,  4, 10,  7,  9,  5,  0, 15, 14,  2,  3, 12},
        '{13,  2,  8,  4,  6, 15, 11,  1, 10,  9,  3, 14,  5,  0, 12,  7,
           1, 15, 13,  8, 10,  3,  7,  4, 12,  5,  6, 11,  0, 14,  9,  2,
           7, 11,  4,  1,  9, 12, 14,  2,  0,  6, 10, 13, 15,  3,  5,  8,
           2,  1, 14,  7,  4, 10,  8, 13, 15, 12,  9,  0,  3,  5,  6, 11}
    };

    // Spread the right half to 48 bits through the E table
    function automatic logic [EXP_W-1:0] drf_expand(input logic [RH_W-1:0] r);
        logic [EXP_W-1:0] e;
        e = '0;
        for (int i = 0; i < EXP_W; i++) begin
            e[EXP_W-1-i] = r[RH_W-E_TAB[i]];
        end
        return e;
    endfunction

    // Substitute each 6-bit group through its S-box
    function automatic logic [F_W-1:0] drf_subst(input logic [EXP_W-1:0] x);
        logic [F_W-1:0] s;
        logic [5:0]     grp;
        s   = '0;
        grp = '0;
        for (int i = 0; i < 8; i++) begin
            grp = x[EXP_W-1-6*i -: 6];
            s[F_W-1-4*i -: 4] = SBOX_TAB[i][{grp[5], grp[0], grp[4:1]}];
        end
        return s;
    endfunction

    // Reorder the S-box word through the P table
    function automatic logic [F_W-1:0] drf_permute(input logic [F_W-1:0] s);
        logic [F_W-1:0] p;
        p = '0;
        for (int i = 0; i < F_W; i++) begin
            p[F_W-1-i] = s[F_W-P_TAB[i]];
        end
        return p;
    endfunction

endpackage

/* src/drf_expand.sv */
// Stage 1: expansion of the right half and key mixing.
`timescale 1ns / 1ps

module drf_expand (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [drf_pkg::RH_W-1:0]   in_right_half,
    input  logic [drf_pkg::KEY_W-1:0]  in_round_key,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [drf_pkg::EXP_W-1:0]  out_mixed
);
    import drf_pkg::*;

    logic             valid_reg;
    logic [EXP_W-1:0] mixed_reg;
    logic [EXP_W-1:0] mixed_next;

    // Advance when the stage is empty or its request moves on
    assign in_ready   = !valid_reg || out_ready;
    assign mixed_next = drf_expand(in_right_half) ^ in_round_key;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Capture payload on acceptance, hold otherwise
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            mixed_reg <= mixed_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_mixed = mixed_reg;

endmodule

/* src/drf_sbox.sv */
// Stage 2: S-box substitution of the key-mixed word.
`timescale 1ns / 1ps

module drf_sbox (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [drf_pkg::EXP_W-1:0]  in_mixed,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [drf_pkg::F_W-1:0]    out_subst
);
    import drf_pkg::*;

    logic           valid_reg;
    logic [F_W-1:0] subst_reg;
    logic [F_W-1:0] subst_next;

    // Advance when the stage is empty or its request moves on
    assign in_ready   = !valid_reg || out_ready;
    assign subst_next = drf_subst(in_mixed);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Capture payload on acceptance, hold otherwise
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            subst_reg <= subst_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_subst = subst_reg;

endmodule

/* src/drf_perm.sv */
// Stage 3: P permutation into the output register.
`timescale 1ns / 1ps

module drf_perm (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [drf_pkg::F_W-1:0]  in_subst,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [drf_pkg::F_W-1:0]  out_result
);
    import drf_pkg::*;

    logic           valid_reg;
    logic [F_W-1:0] result_reg;
    logic [F_W-1:0] result_next;

    // Advance when the stage is empty or its request is taken
    assign in_ready    = !valid_reg || out_ready;
    assign result_next = drf_permute(in_subst);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Capture payload on acceptance, hold otherwise
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

/* src/des_round_function.sv */
// DES round function f: expand and key mix, S-box substitution, P permutation.
// A request passes three registers, one per stage, from acceptance to result valid.
// Throughput: one request per cycle while m_ready is high; each stage holds one
// request, freed as it moves on: a full pipeline under back-pressure loses nothing.
// Reset (aresetn low, synchronous) clears the stage valid bits only.
`timescale 1ns / 1ps

module des_round_function (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [drf_pkg::RH_W-1:0]   s_right_half,
    input  logic [drf_pkg::KEY_W-1:0]  s_round_key,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [drf_pkg::F_W-1:0]    m_f_result
);
    import drf_pkg::*;

    logic             mix_valid;
    logic             mix_ready;
    logic [EXP_W-1:0] mix_data;
    logic             sub_valid;
    logic             sub_ready;
    logic [F_W-1:0]   sub_data;

    // Expand and mix with the round key
    drf_expand u_expand (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .in_right_half (s_right_half),
        .in_round_key  (s_round_key),
        .out_valid     (mix_valid),
        .out_ready     (mix_ready),
        .out_mixed     (mix_data)
    );

    // Substitute through S1..S8
    drf_sbox u_sbox (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mix_valid),
        .in_ready  (mix_ready),
        .in_mixed  (mix_data),
        .out_valid (sub_valid),
        .out_ready (sub_ready),
        .out_subst (sub_data)
    );

    // Permute and present the result
    drf_perm u_perm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (sub_valid),
        .in_ready   (sub_ready),
        .in_subst   (sub_data),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_result (m_f_result)
    );

endmodule
